// ----- sv/xtea_block_cipher_defines.svh -----
// Assertion macros shared by the XTEA cipher checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef XTEA_BLOCK_CIPHER_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_DEFINES_SVH

// Check that an expression holds at every clock edge out of reset.
`define XTEA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds whenever an antecedent holds.
`define XTEA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/xtea_pkg.sv -----
// Shared types and constants of the XTEA block cipher.
// No dependencies.
`default_nettype none

package xtea_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_KEYS    = 4;
    localparam int KEY_IDX_W   = 2;
    localparam int NUM_CELLS   = 64;

    localparam logic [WORD_W-1:0] DELTA     = 32'h9E3779B9;
    localparam logic [WORD_W-1:0] DEC_START = 32'hC6EF3720;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = 2'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = 2'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = 2'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = 2'd3;

    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_set_t;

    typedef struct packed {
        logic              valid;
        logic              mode;
        logic              phase;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] q;
    } lane_t;

endpackage

`default_nettype wire

// ----- sv/xtea_cell.sv -----
// One XTEA half-round cell of the cipher chain.
// Depends on xtea_pkg for the lane type, key set and round constant.
`default_nettype none

module xtea_cell
    import xtea_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire key_set_t keys,
    input  wire lane_t    lane_in,
    output lane_t         lane_out
);

    logic                 sel_hi;
    logic [KEY_IDX_W-1:0] key_idx;
    logic [WORD_W-1:0]    mix;
    logic [WORD_W-1:0]    term;
    logic [WORD_W-1:0]    word_new;
    logic [WORD_W-1:0]    sum_step;
    lane_t                lane_next;
    logic                 valid_reg;
    lane_t                data_reg;

    always_comb
    begin
        sel_hi   = lane_in.phase ^ lane_in.mode;
        key_idx  = sel_hi ? lane_in.sum[12:11] : lane_in.sum[1:0];
        mix      = ((lane_in.p << 4) ^ (lane_in.p >> 5)) + lane_in.p;
        term     = mix ^ (lane_in.sum + keys[key_idx]);
        word_new = (lane_in.mode == MODE_DEC) ? (lane_in.q - term) : (lane_in.q + term);
        sum_step = (lane_in.mode == MODE_DEC) ? (lane_in.sum - DELTA) : (lane_in.sum + DELTA);

        lane_next       = lane_in;
        lane_next.phase = ~lane_in.phase;
        lane_next.sum   = lane_in.phase ? lane_in.sum : sum_step;
        lane_next.p     = word_new;
        lane_next.q     = lane_in.p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= lane_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= lane_next;
    end

    always_comb
    begin
        lane_out       = data_reg;
        lane_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ----- sv/xtea_block_cipher.sv -----
// XTEA cipher, 64-bit block, 128-bit key: a chain of 64 half-round cells.
// done and the result words are taken from the registers of the last cell.
// Throughput: one block per cycle; busy is always low, one cell per half-round.
// Reset clears the key words and every valid bit in the chain.
// Depends on xtea_pkg and xtea_cell.
`default_nettype none

module xtea_block_cipher
    import xtea_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [KEY_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 mode,
    input  wire logic [WORD_W-1:0]    block_low_word,
    input  wire logic [WORD_W-1:0]    block_high_word,
    output logic                      done,
    output logic [WORD_W-1:0]         result_low_word,
    output logic [WORD_W-1:0]         result_high_word
);

    key_set_t key_reg;
    key_set_t key_next;
    lane_t    chain [NUM_CELLS+1];
    lane_t    last;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                KEY_IDX_0: key_next[0] = cfg_data;
                KEY_IDX_1: key_next[1] = cfg_data;
                KEY_IDX_2: key_next[2] = cfg_data;
                KEY_IDX_3: key_next[3] = cfg_data;
                default:   key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign busy = 1'b0;

    always_comb
    begin
        chain[0].valid = start && !busy;
        chain[0].mode  = mode;
        chain[0].phase = 1'b0;
        chain[0].sum   = (mode == MODE_DEC) ? DEC_START : '0;
        chain[0].p     = (mode == MODE_DEC) ? block_low_word : block_high_word;
        chain[0].q     = (mode == MODE_DEC) ? block_high_word : block_low_word;
    end

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        xtea_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .keys     (key_reg),
            .lane_in  (chain[i]),
            .lane_out (chain[i+1])
        );
    end

    assign last             = chain[NUM_CELLS];
    assign done             = last.valid;
    assign result_low_word  = (last.mode == MODE_DEC) ? last.p : last.q;
    assign result_high_word = (last.mode == MODE_DEC) ? last.q : last.p;

endmodule

`default_nettype wire

// ----- sv/xtea_checker.sv -----
// Port-level checker for the XTEA cipher, bound to the top level.
// Depends on xtea_pkg and xtea_block_cipher_defines.svh.
`default_nettype none

`include "xtea_block_cipher_defines.svh"

module xtea_checker
    import xtea_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    localparam int WARM_W = $clog2(NUM_CELLS + 1);

    logic [WARM_W-1:0] warm_cnt_reg;
    logic [WARM_W-1:0] warm_cnt_next;
    logic              warm;

    assign warm          = (warm_cnt_reg == WARM_W'(NUM_CELLS));
    assign warm_cnt_next = warm ? warm_cnt_reg : warm_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= '0;
        end
        else
        begin
            warm_cnt_reg <= warm_cnt_next;
        end
    end

    `XTEA_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `XTEA_ASSERT_IMPLY(a_no_early_done, !warm, !done, "done before chain filled")
    `XTEA_ASSERT_IMPLY(a_done_latency, warm, done == $past(start && !busy, NUM_CELLS), "done latency")

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
